// File: rtl/ebds_pkg.sv
`timescale 1ns / 1ps
// Shared constants and controller/datapath interface types for the elevator
// batch disk scheduler. No dependencies.
package ebds_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int ADDR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int LOC_W       = 30;
    localparam int PID_W       = 30;
    localparam int KEY_W       = LOC_W + PID_W;
    localparam int TIME_W      = 32;
    localparam int SVC_W       = 16;
    localparam logic [SVC_W-1:0] SVC_RESET = 16'd5;

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DRAIN   = 1'b1;

    localparam logic REG_SERVICE_TIME = 1'b0;

    typedef struct packed {
        logic enq;
        logic drain_empty;
        logic drain_start;
        logic scan_step;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic count_zero;
        logic scan_last;
        logic emit_last;
    } t_status;

endpackage

// File: rtl/ebds_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the scheduler: accepts commands and steps the datapath
// through repeated scan and emit phases. Depends on ebds_pkg.
module ebds_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  logic             i_op,
    input  ebds_pkg::t_status i_status,
    output ebds_pkg::t_cmd   o_cmd,
    output logic             busy
);
    import ebds_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_TAIL = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_op == OP_ENQUEUE) begin
                        o_cmd.enq = 1'b1;
                    end else if (i_status.count_zero) begin
                        o_cmd.drain_empty = 1'b1;
                    end else begin
                        o_cmd.drain_start = 1'b1;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_last) begin
                    n_state = S_TAIL;
                end
            end
            // The last read entry is compared in this cycle.
            S_TAIL: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                n_state = i_status.emit_last ? S_IDLE : S_SCAN;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

// File: rtl/ebds_datapath.sv
`timescale 1ns / 1ps
// Request memory, scan with one shared key comparator, time accumulator and
// result registers. Depends on ebds_pkg.
module ebds_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ebds_pkg::t_cmd                 i_cmd,
    input  logic [ebds_pkg::LOC_W-1:0]     i_location,
    input  logic [ebds_pkg::PID_W-1:0]     i_process_id,
    input  logic [ebds_pkg::TIME_W-1:0]    i_start_time,
    input  logic [ebds_pkg::SVC_W-1:0]     i_service_time,
    output ebds_pkg::t_status              o_status,
    output logic                           o_valid,
    output logic [ebds_pkg::PID_W-1:0]     o_served_process,
    output logic [ebds_pkg::LOC_W-1:0]     o_served_location,
    output logic [ebds_pkg::TIME_W-1:0]    o_finish_time,
    output logic                           o_last,
    output logic                           o_dropped_any
);
    import ebds_pkg::*;

    logic [KEY_W-1:0]       r_mem [QUEUE_DEPTH];
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       r_remaining;
    logic                   r_sweep_down;
    logic                   r_overflow;
    logic                   r_flag;
    logic [TIME_W-1:0]      r_time;
    logic [QUEUE_DEPTH-1:0] r_served;
    logic [ADDR_W-1:0]      r_idx;
    logic [KEY_W-1:0]       r_rd_data;
    logic [ADDR_W-1:0]      r_rd_idx;
    logic                   r_rd_vld;
    logic [KEY_W-1:0]       r_best;
    logic [ADDR_W-1:0]      r_best_idx;
    logic                   r_best_vld;
    logic [TIME_W-1:0]      n_time;
    logic                   better;
    logic                   take;

    assign n_time = r_time + {{(TIME_W-SVC_W){1'b0}}, i_service_time};
    assign better = r_sweep_down ? (r_rd_data > r_best) : (r_rd_data < r_best);
    assign take   = r_rd_vld && !r_served[r_rd_idx] && (!r_best_vld || better);

    assign o_status.count_zero = (r_count == '0);
    assign o_status.scan_last  = ({1'b0, r_idx} == (r_count - CNT_W'(1)));
    assign o_status.emit_last  = (r_remaining == CNT_W'(1));

    // Memory: one write port for enqueue, one registered read port for the scan.
    always_ff @(posedge i_clk) begin
        if (i_cmd.enq && (r_count != CNT_W'(QUEUE_DEPTH))) begin
            r_mem[r_count[ADDR_W-1:0]] <= {i_location, i_process_id};
        end
        if (i_cmd.scan_step) begin
            r_rd_data <= r_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_remaining  <= '0;
            r_sweep_down <= 1'b0;
            r_overflow   <= 1'b0;
            r_rd_vld     <= 1'b0;
            r_best_vld   <= 1'b0;
            r_idx        <= '0;
            r_served     <= '0;
            o_valid      <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.scan_step;
            o_valid  <= i_cmd.emit;
            if (i_cmd.enq) begin
                if (r_count != CNT_W'(QUEUE_DEPTH)) begin
                    r_count <= r_count + CNT_W'(1);
                end else begin
                    r_overflow <= 1'b1;
                end
            end
            if (i_cmd.drain_empty) begin
                r_sweep_down <= !r_sweep_down;
                r_overflow   <= 1'b0;
            end
            if (i_cmd.drain_start) begin
                r_remaining <= r_count;
                r_served    <= '0;
                r_idx       <= '0;
                r_best_vld  <= 1'b0;
            end
            if (i_cmd.scan_step) begin
                r_idx <= r_idx + ADDR_W'(1);
            end
            if (take) begin
                r_best_vld <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_served[r_best_idx] <= 1'b1;
                r_remaining          <= r_remaining - CNT_W'(1);
                r_idx                <= '0;
                r_best_vld           <= 1'b0;
                if (r_remaining == CNT_W'(1)) begin
                    r_count      <= '0;
                    r_sweep_down <= !r_sweep_down;
                    r_overflow   <= 1'b0;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_step) begin
            r_rd_idx <= r_idx;
        end
        if (take) begin
            r_best     <= r_rd_data;
            r_best_idx <= r_rd_idx;
        end
        if (i_cmd.drain_start) begin
            r_time <= i_start_time;
            r_flag <= r_overflow;
        end
        if (i_cmd.emit) begin
            r_time            <= n_time;
            o_finish_time     <= n_time;
            o_served_location <= r_best[KEY_W-1:PID_W];
            o_served_process  <= r_best[PID_W-1:0];
            o_last            <= (r_remaining == CNT_W'(1));
            o_dropped_any     <= r_flag;
        end
    end

endmodule

// File: rtl/elevator_batch_disk_scheduler_core.sv
`timescale 1ns / 1ps
// Top level of the elevator batch disk scheduler: APB register, controller
// and datapath. Depends on ebds_pkg, ebds_ctrl and ebds_datapath.

// An enqueue beat keeps busy low. A drain beat with N pending requests gives
// N results in turn: each result needs a full pass over the N stored requests
// through the single read port of the request memory and one key comparator,
// then a tail step to finish the last compare and an emit step. A drain of an
// empty store gives no result. Results appear on the o_ ports for exactly one
// cycle with o_valid high and cannot be held off; the next beat may be started
// while the final result of a drain is still on the ports.
module elevator_batch_disk_scheduler_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_op,
    input  logic [ebds_pkg::LOC_W-1:0]  i_location,
    input  logic [ebds_pkg::PID_W-1:0]  i_process_id,
    input  logic [ebds_pkg::TIME_W-1:0] i_start_time,
    output logic                        o_valid,
    output logic [ebds_pkg::PID_W-1:0]  o_served_process,
    output logic [ebds_pkg::LOC_W-1:0]  o_served_location,
    output logic [ebds_pkg::TIME_W-1:0] o_finish_time,
    output logic                        o_last,
    output logic                        o_dropped_any,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import ebds_pkg::*;

    logic [SVC_W-1:0] r_service_time;
    t_cmd             cmd;
    t_status          status;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SERVICE_TIME) ?
                    {{(32-SVC_W){1'b0}}, r_service_time} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_service_time <= SVC_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == REG_SERVICE_TIME)) begin
            r_service_time <= pwdata[SVC_W-1:0];
        end
    end

    ebds_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_op     (i_op),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    ebds_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_location        (i_location),
        .i_process_id      (i_process_id),
        .i_start_time      (i_start_time),
        .i_service_time    (r_service_time),
        .o_status          (status),
        .o_valid           (o_valid),
        .o_served_process  (o_served_process),
        .o_served_location (o_served_location),
        .o_finish_time     (o_finish_time),
        .o_last            (o_last),
        .o_dropped_any     (o_dropped_any)
    );

endmodule
